>>> src/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg : shared types, codes and mapping functions
// Holds the module-pair tables, the status and pair-kind codes and the
// crystal index arithmetic used by the list-mode word decoder.
// ----------------------------------------------------------------------------
package pld_pkg;

  // Crystal index geometry
  localparam int unsigned ScnCry   = 169;
  localparam int unsigned InsBase  = 126336;
  localparam int unsigned CryW     = 18;
  localparam int unsigned TimeW    = 29;

  // Status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_INS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_COORD_RANGE = 2'd2;

  // Pair kinds
  localparam logic KIND_SS = 1'b0;
  localparam logic KIND_SI = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WINDOW_START = 2'd0;
  localparam logic [1:0] REG_WINDOW_END   = 2'd1;
  localparam logic [1:0] REG_TIME_OFFSET  = 2'd2;

  // Scanner-scanner module pairs, entry n for pair code n+1
  localparam logic [3:0] SS_MOD_A [42] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6,
    4'd7, 4'd7, 4'd8};
  localparam logic [3:0] SS_MOD_B [42] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10,
    4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
    4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd8, 4'd9, 4'd10, 4'd11, 4'd9, 4'd10, 4'd11,
    4'd10, 4'd11, 4'd11};

  // Scanner-insert module pairs, entry n for pair code n+1
  localparam logic [3:0] IS_MOD_A [18] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11,
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11};
  localparam logic [3:0] IS_MOD_B [18] = '{
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12,
    4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13};

  // Decoded word passed from the mapper to the output stage
  typedef struct packed {
    logic              marker;
    logic [TimeW-1:0]  marker_time;
    logic              keep;
    logic              kind;
    logic [1:0]        status;
    logic [CryW-1:0]   crystal_a;
    logic [CryW-1:0]   crystal_b;
    logic              prompt;
  } pld_event_t;

  // Split a coordinate below 52 into quotient and remainder by 13
  function automatic logic [5:0] div13(input logic [5:0] v);
    logic [1:0] q;
    logic [3:0] r;
    begin
      if (v >= 6'd39) begin
        q = 2'd3;
        r = 4'(v - 6'd39);
      end else if (v >= 6'd26) begin
        q = 2'd2;
        r = 4'(v - 6'd26);
      end else if (v >= 6'd13) begin
        q = 2'd1;
        r = 4'(v - 6'd13);
      end else begin
        q = 2'd0;
        r = v[3:0];
      end
      return {q, r};
    end
  endfunction

  // Scanner crystal index from module and in-range coordinates
  function automatic logic [14:0] scanner_index(input logic [3:0] mod,
                                                input logic [5:0] cx,
                                                input logic [5:0] cy);
    logic [5:0] dx;
    logic [5:0] dy;
    logic [5:0] sec_raw;
    logic [5:0] sec;
    logic [7:0] n;
    logic [7:0] cry;
    begin
      dx      = div13(cx);
      dy      = div13(cy);
      sec_raw = {mod, 2'b00} + {4'd0, dx[5:4]} + 6'd10;
      sec     = (sec_raw >= 6'd48) ? 6'(sec_raw - 6'd48) : sec_raw;
      n       = {sec, ~dy[5:4]};
      cry     = 8'((8'd12 - {4'd0, dy[3:0]}) * 8'd13) + {4'd0, dx[3:0]};
      return 15'({8'd0, n} * 16'(ScnCry) + {8'd0, cry});
    end
  endfunction

  // Insert crystal index; undo the junction-board swap of module 13
  function automatic logic [17:0] insert_index(input logic [3:0] mod,
                                               input logic [5:0] cx,
                                               input logic [5:0] cy);
    logic [5:0] x;
    logic [5:0] y;
    logic [4:0] n;
    begin
      x = cx;
      y = cy;
      if (mod == 4'd13 && cx[4]) begin
        x = cx[5] ? 6'(7'd111 - {1'b0, cx}) : 6'(7'd47 - {1'b0, cx});
        y = cy[4] ? 6'(7'd79 - {1'b0, cy}) : 6'(7'd47 - {1'b0, cy});
      end
      n = {~y[5:4], 3'b000} + {3'd0, ~x[5:4]} + ((mod == 4'd12) ? 5'd4 : 5'd0);
      return 18'(InsBase) + {5'd0, n, ~y[3:0], ~x[3:0]};
    end
  endfunction

endpackage

>>> src/pld_event_map.sv
// ----------------------------------------------------------------------------
// pld_event_map : list-mode word decode and crystal mapping
// Splits one word into a time marker or an event, looks up the module pair
// and maps both crystal coordinates to global crystal indices.
// ----------------------------------------------------------------------------
module pld_event_map
  import pld_pkg::*;
(
  input  logic [63:0] raw_word,
  output pld_event_t  dec
);

  logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7;
  logic [5:0] mp;
  logic [5:0] emp;
  logic       ss_hit;
  logic       si_hit;
  logic [5:0] ss_idx;
  logic [4:0] si_idx;
  logic [3:0] mod_a;
  logic [3:0] mod_b;
  logic [7:0] ax, ay, bx, by;
  logic       scn_bad;
  logic       ins_bad;
  logic [14:0] scn_a;
  logic [14:0] scn_b;
  logic [17:0] ins_b;

  // Split into bytes
  assign {b7, b6, b5, b4, b3, b2, b1, b0} = raw_word;

  // Pair codes and table lookup
  assign mp     = {b6[2:0], b2[2:0]};
  assign emp    = {b6[5:3], b2[5:3]};
  assign ss_hit = (mp != 6'd0) && (mp <= 6'd42);
  assign si_hit = (mp == 6'd0) && (emp != 6'd0) && (emp <= 6'd18);
  assign ss_idx = 6'(mp - 6'd1);
  assign si_idx = 5'(emp - 6'd1);
  assign mod_a  = ss_hit ? SS_MOD_A[ss_idx] : IS_MOD_A[si_idx];
  assign mod_b  = ss_hit ? SS_MOD_B[ss_idx] : IS_MOD_B[si_idx];

  // Scanner side sits in the low bytes for a scanner pair, high bytes otherwise
  assign ax = ss_hit ? b0 : b4;
  assign ay = ss_hit ? b1 : b5;
  assign bx = ss_hit ? b4 : b0;
  assign by = ss_hit ? b5 : b1;

  // Range checks
  assign scn_bad = (ax >= 8'd52) || (ay >= 8'd52) ||
                   (ss_hit && ((bx >= 8'd52) || (by >= 8'd52)));
  assign ins_bad = (bx >= 8'd64) || (by >= 8'd64);

  // Crystal indices
  assign scn_a = scanner_index(mod_a, ax[5:0], ay[5:0]);
  assign scn_b = scanner_index(mod_b, bx[5:0], by[5:0]);
  assign ins_b = insert_index(mod_b, bx[5:0], by[5:0]);

  // Assemble decoded word
  always_comb begin
    dec             = '0;
    dec.marker      = b3[6] && (b5[7:5] == 3'b100);
    dec.marker_time = {b5[4:0], b4, b1, b0};
    dec.keep        = !b3[6] && (ss_hit || si_hit);
    dec.kind        = ss_hit ? KIND_SS : KIND_SI;
    dec.prompt      = b7[6];
    if (scn_bad) begin
      dec.status = STATUS_COORD_RANGE;
    end else if (ss_hit) begin
      dec.status    = STATUS_OK;
      dec.crystal_a = {3'd0, scn_a};
      dec.crystal_b = {3'd0, scn_b};
    end else if (ins_bad) begin
      dec.status    = STATUS_INS_RANGE;
      dec.crystal_a = {3'd0, scn_a};
    end else begin
      dec.status    = STATUS_OK;
      dec.crystal_a = {3'd0, scn_a};
      dec.crystal_b = ins_b;
    end
  end

endmodule

>>> src/pet_listmode_word_decoder_top.sv
// ----------------------------------------------------------------------------
// pet_listmode_word_decoder_top : PET list-mode word decoder
// Registers each word, decodes it in one pass and holds the event in an
// output register; time markers load the time register.
// ----------------------------------------------------------------------------
// Path: the accepting edge loads the input register; the event then moves to
// the result register once that register is free to take it.
// Throughput: one word per cycle; the input stalls only while a result waits
// in the output register and the word in the input register has an event to emit.
// Reset: clears both valid flags and the time register, and returns the
// window start to zero, the window end to all ones and the time offset to zero.
module pet_listmode_word_decoder_top
  import pld_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // Word channel
  input  logic                     word_valid,
  output logic                     word_stall,
  input  logic [63:0]              raw_word,
  // Event channel
  output logic                     event_valid,
  input  logic                     event_stall,
  output logic [CryW-1:0]          crystal_a,
  output logic [CryW-1:0]          crystal_b,
  output logic [32:0]              event_time,
  output logic                     prompt_flag,
  output logic                     pair_kind,
  output logic [1:0]               status
);

  logic [TimeW-1:0] window_start;
  logic [TimeW-1:0] window_end;
  logic [31:0]      time_offset;
  logic [TimeW-1:0] current_time;
  logic             s1_valid;
  logic [63:0]      s1_word;
  pld_event_t       dec;
  logic             in_window;
  logic             emit;
  logic             out_free;
  logic             s1_move;
  logic             cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '1;
      time_offset  <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_WINDOW_START: window_start <= pwdata[TimeW-1:0];
        REG_WINDOW_END:   window_end   <= pwdata[TimeW-1:0];
        REG_TIME_OFFSET:  time_offset  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW_START: prdata = {3'd0, window_start};
      REG_WINDOW_END:   prdata = {3'd0, window_end};
      REG_TIME_OFFSET:  prdata = time_offset;
      default:          prdata = '0;
    endcase
  end

  // Decode the registered word
  pld_event_map u_map (
    .raw_word (s1_word),
    .dec      (dec)
  );

  // Flow control
  assign in_window  = (current_time > window_start) && (current_time < window_end);
  assign emit       = dec.keep && in_window;
  assign out_free   = !event_valid || !event_stall;
  assign s1_move    = s1_valid && (out_free || !emit);
  assign word_stall = s1_valid && !s1_move;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (word_valid && !word_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && !word_stall) begin
      s1_word <= raw_word;
    end
  end

  // Time register: load on a time marker leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
    end else if (s1_move && dec.marker) begin
      current_time <= dec.marker_time;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (s1_move && emit) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && emit) begin
      crystal_a   <= dec.crystal_a;
      crystal_b   <= dec.crystal_b;
      event_time  <= {4'd0, current_time} + {1'b0, time_offset};
      prompt_flag <= dec.prompt;
      pair_kind   <= dec.kind;
      status      <= dec.status;
    end
  end

`ifndef ASSERT_OFF
  // A flagged event never carries a second crystal
  assert property (@(posedge clk) disable iff (rst)
    event_valid && status != STATUS_OK |-> crystal_b == '0)
    else $error("flagged event carries a second crystal");

  // A coordinate fault clears the first crystal too
  assert property (@(posedge clk) disable iff (rst)
    event_valid && status == STATUS_COORD_RANGE |-> crystal_a == '0)
    else $error("coordinate fault with non-zero first crystal");

  // Scanner pairs have no insert range fault
  assert property (@(posedge clk) disable iff (rst)
    event_valid && pair_kind == KIND_SS |-> status != STATUS_INS_RANGE)
    else $error("insert range fault on scanner pair");

  // A marker leaving the input register loads the time register
  assert property (@(posedge clk) disable iff (rst)
    s1_move && dec.marker |=> current_time == $past(dec.marker_time))
    else $error("time marker not loaded");

  // The input stalls only behind a held event
  assert property (@(posedge clk) disable iff (rst)
    word_stall |-> s1_valid && emit && event_valid && event_stall)
    else $error("input stalled without cause");
`endif

endmodule
